// ===== rtl/polyphase_synthesis_filterbank_core_assert.svh =====
// Assertion macros for the filterbank RTL.
`ifndef POLYPHASE_SYNTHESIS_FILTERBANK_CORE_ASSERT_SVH
`define POLYPHASE_SYNTHESIS_FILTERBANK_CORE_ASSERT_SVH

// Same-cycle implication on clk, held off while reset is asserted.
`define PSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, held off while reset is asserted.
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/psf_pkg.sv =====
// Types, constants and coefficient tables of the synthesis filterbank.
package psf_pkg;

	localparam int SMP_W     = 24;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = COEF_W - 2;
	localparam int V_W       = 32;
	localparam int SUBBANDS  = 32;
	localparam int BLOCK     = 64;
	localparam int HIST_LEN  = 1024;
	localparam int TAPS      = 16;
	localparam int WIN_LEN   = 512;
	localparam int SECOND_HALF = 96;
	localparam int SLOT_AW   = 6;
	localparam int PROD_W    = V_W + COEF_W;
	localparam int ACC_W     = PROD_W + 5;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MAT,
		BK_DRAIN,
		BK_WIN
	} bk_state_t;

	typedef enum logic {
		PH_MAT,
		PH_WIN
	} phase_t;

	// back end status toward the front end
	typedef struct packed {
		logic clr_busy;
		logic rel_valid;
		logic rel_ch;
	} back_stat_t;

	// slot sample read port
	typedef struct packed {
		logic               en;
		logic [SLOT_AW-1:0] addr;
	} smp_rd_t;

	// per-term tag that travels along the MAC pipeline
	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		phase_t     ph;
		logic       ch;
		logic       slot_end;
		logic [5:0] idx;
	} tag_t;

	// one PCM word waiting at the output
	typedef struct packed {
		logic             ch;
		logic [SMP_W-1:0] pcm;
		logic             last;
	} out_t;

	// cos(m*pi/64) in Q2.16, m = 0..32
	localparam int COS_Q [0:32] = '{
		65536, 65457, 65220, 64827, 64277, 63572, 62714, 61705,
		60547, 59244, 57798, 56212, 54491, 52639, 50660, 48559,
		46341, 44011, 41576, 39040, 36410, 33692, 30893, 28020,
		25080, 22078, 19024, 15924, 12785, 9616, 6424, 3216, 0
	};

	// synthesis window, first half, units of 2^-16, before sign pattern
	localparam int WIN_BASE [0:256] = '{
		0,-1,-1,-1,-1,-1,-1,-2,-2,-2,-2,-3,-3,-4,-4,-5,-5,-6,-7,-7,-8,-9,-10,-11,
		-13,-14,-16,-17,-19,-21,-24,-26,-29,-31,-35,-38,-41,-45,-49,-53,-58,-63,
		-68,-73,-79,-85,-91,-97,-104,-111,-117,-125,-132,-139,-147,-154,-161,-169,
		-176,-183,-190,-196,-202,-208,-213,-218,-222,-225,-227,-228,-228,-227,-224,
		-221,-215,-208,-200,-189,-177,-163,-146,-127,-106,-83,-57,-29,2,36,72,111,
		153,197,244,294,347,401,459,519,581,645,711,779,848,919,991,1064,1137,1210,
		1283,1356,1428,1498,1567,1634,1698,1759,1817,1870,1919,1962,2001,2032,2057,
		2075,2085,2087,2080,2063,2037,2000,1952,1893,1822,1739,1644,1535,1414,1280,
		1131,970,794,605,402,185,-45,-288,-545,-814,-1095,-1388,-1692,-2006,-2330,
		-2663,-3004,-3351,-3705,-4063,-4425,-4788,-5153,-5517,-5879,-6237,-6589,
		-6935,-7271,-7597,-7910,-8209,-8491,-8755,-8998,-9219,-9416,-9585,-9727,
		-9838,-9916,-9959,-9966,-9935,-9863,-9750,-9592,-9389,-9139,-8840,-8492,
		-8092,-7640,-7134,-6574,-5959,-5288,-4561,-3776,-2935,-2037,-1082,-70,998,
		2122,3300,4533,5818,7154,8540,9975,11455,12980,14548,16155,17799,19478,
		21189,22929,24694,26482,28289,30112,31947,33791,35640,37489,39336,41176,
		43006,44821,46617,48390,50137,51853,53534,55178,56778,58333,59838,61289,
		62684,64019,65290,66494,67629,68692,69679,70590,71420,72169,72835,73415,
		73908,74313,74630,74856,74992,75038
	};

	// matrixing coefficient for a 7-bit phase index, from the quarter wave
	function automatic coef_t cos_coef(input logic [6:0] m);
		int mi;
		int v;
		mi = int'(m);
		if (mi <= 32)
			v = COS_Q[mi];
		else if (mi <= 64)
			v = -COS_Q[64 - mi];
		else if (mi <= 96)
			v = -COS_Q[mi - 64];
		else
			v = COS_Q[128 - mi];
		return coef_t'(v);
	endfunction

	// window coefficient D[n], mirrored around the center, sign flipped on odd blocks of 64
	function automatic coef_t win_coef(input logic [8:0] n);
		int ni;
		int d;
		ni = int'(n);
		d = (ni <= 256) ? WIN_BASE[ni] : WIN_BASE[WIN_LEN - ni];
		if (n[6])
			d = -d;
		return coef_t'(d);
	endfunction

endpackage

// ===== rtl/psf_front.sv =====
// Front end: takes subband words, stores the slot samples, queues synthesis jobs.
module psf_front
	import psf_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_ch,
	input  logic [4:0]              in_sb,
	input  logic [SMP_W-1:0]        in_smp,
	input  back_stat_t              stat,
	output logic                    job_push,
	output logic                    job_ch,
	input  logic                    job_full,
	input  smp_rd_t                 smp_rd,
	output logic signed [SMP_W-1:0] smp_rdata
);

	logic [1:0]              pend_q;
	logic                    ch_ok;
	logic                    is_last;
	logic                    accept;
	logic signed [SMP_W-1:0] slot_mem [0:2*SUBBANDS-1];
	logic signed [SMP_W-1:0] rdata_q;

	assign ch_ok   = (int'(in_ch) < CHANNELS);
	assign is_last = (in_sb == 5'(SUBBANDS - 1));

	// hold in V clear, on job_full, or while a channel's slot is unmatrixed
	always_comb begin
		in_ready = 1'b0;
		if (!stat.clr_busy) begin
			if (!ch_ok)
				in_ready = 1'b1;
			else
				in_ready = !pend_q[in_ch] && (!is_last || !job_full);
		end
	end

	assign accept   = in_valid && in_ready;
	assign job_push = accept && ch_ok && is_last;
	assign job_ch   = in_ch;

	// per-channel job pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if (stat.rel_valid)
				pend_q[stat.rel_ch] <= 1'b0;
			if (job_push)
				pend_q[job_ch] <= 1'b1;
		end
	end

	// slot sample store
	always_ff @(posedge clk) begin
		if (accept && ch_ok)
			slot_mem[{in_ch, in_sb}] <= in_smp;
		if (smp_rd.en)
			rdata_q <= slot_mem[smp_rd.addr];
	end

	assign smp_rdata = rdata_q;

endmodule

// ===== rtl/psf_job_fifo.sv =====
// Two-entry queue of synthesis jobs between front and back end.
module psf_job_fifo
	import psf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_ch,
	output logic full,
	input  logic pop,
	output logic valid,
	output logic head_ch
);

	logic [1:0] data_q;
	logic [1:0] cnt_q;
	logic [1:0] wr_pos;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign head_ch = data_q[0];
	assign wr_pos  = pop ? (cnt_q - 2'd1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
	end

	// entry 0 is the head; a push into the head slot wins over the shift
	always_ff @(posedge clk) begin
		if (push && !wr_pos[0])
			data_q[0] <= push_ch;
		else if (pop)
			data_q[0] <= data_q[1];
		if (push && wr_pos[0])
			data_q[1] <= push_ch;
	end

endmodule

// ===== rtl/psf_back.sv =====
// Back end: V history, shared MAC for matrixing and windowing, PCM output queue.
module psf_back
	import psf_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	input  logic                    job_ch,
	output logic                    job_pop,
	output back_stat_t              stat,
	output smp_rd_t                 smp_rd,
	input  logic signed [SMP_W-1:0] smp_rdata,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_ch,
	output logic [SMP_W-1:0]        out_pcm,
	output logic                    out_last
);

	localparam int VDEPTH = CHANNELS * HIST_LEN;
	localparam int VAW    = $clog2(VDEPTH);

	bk_state_t state_q, state_d;
	logic [VAW-1:0] clr_q;
	logic [3:0]     voff_q [2];
	logic           ch_q;
	logic [3:0]     base_q;
	logic [5:0]     outer_q;
	logic [4:0]     inner_q;
	logic           mat_done;
	logic           adv;
	logic           res_s3;

	tag_t                    tag_i, tag_s1, tag_s2, tag_s3;
	coef_t                   coef_i, coef_s1;
	logic [6:0]              cos_m;
	logic [12:0]             cos_prod;
	logic [3:0]              tap;
	logic [4:0]              col;
	logic [9:0]              vi;
	logic [9:0]              vrd_off;
	logic [VAW-1:0]          vrd_addr;
	logic                    vrd_en;
	logic signed [V_W-1:0]   vmem [0:VDEPTH-1];
	logic signed [V_W-1:0]   vrd_s1;
	logic signed [V_W-1:0]   opnd;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [ACC_W-1:0] rnd;
	logic                    v_ovf;
	logic                    p_ovf;
	logic [V_W-1:0]          vres;
	logic [SMP_W-1:0]        pres;
	logic                    vwe;
	logic [VAW-1:0]          vwr_addr;
	logic [V_W-1:0]          vwr_data;

	out_t       oq_q [2];
	logic [1:0] oq_cnt_q;
	logic [1:0] oq_wr;
	logic       oq_push;
	logic       oq_pop;
	logic       oq_full;
	out_t       oq_in;

	// stall only when a PCM result has nowhere to go
	assign res_s3  = tag_s3.vld && tag_s3.last;
	assign oq_full = (oq_cnt_q == 2'd2);
	assign adv     = !(res_s3 && (tag_s3.ph == PH_WIN) && oq_full);

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		mat_done = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == VAW'(VDEPTH - 1))
					state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_MAT;
				end
			end
			BK_MAT: begin
				if (adv && outer_q == 6'(BLOCK - 1) && inner_q == 5'(SUBBANDS - 1)) begin
					mat_done = 1'b1;
					state_d  = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!tag_s1.vld && !tag_s2.vld && !res_s3)
					state_d = BK_WIN;
			end
			BK_WIN: begin
				if (adv && outer_q[4:0] == 5'(SUBBANDS - 1) && inner_q[3:0] == 4'(TAPS - 1))
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign stat.clr_busy  = (state_q == BK_CLEAR);
	assign stat.rel_valid = mat_done;
	assign stat.rel_ch    = ch_q;

	// issue stage: operand addresses and coefficient of the current term
	assign tap = inner_q[3:0];
	assign col = outer_q[4:0];
	assign vi  = {tap[3:1], 7'd0} + (tap[0] ? 10'(SECOND_HALF) : 10'd0) + 10'(col);
	assign vrd_off  = {base_q, 6'd0} + vi;
	assign vrd_addr = VAW'({ch_q, vrd_off});
	assign cos_prod = 13'({1'b0, outer_q} + 7'd16) * 13'({inner_q, 1'b1});
	assign cos_m    = cos_prod[6:0];

	always_comb begin
		tag_i       = '0;
		tag_i.ch    = ch_q;
		tag_i.idx   = outer_q;
		coef_i      = '0;
		smp_rd.en   = 1'b0;
		smp_rd.addr = {ch_q, inner_q};
		vrd_en      = 1'b0;
		case (state_q)
			BK_MAT: begin
				tag_i.vld   = 1'b1;
				tag_i.ph    = PH_MAT;
				tag_i.first = (inner_q == 5'd0);
				tag_i.last  = (inner_q == 5'(SUBBANDS - 1));
				coef_i      = cos_coef(cos_m);
				smp_rd.en   = adv;
			end
			BK_WIN: begin
				tag_i.vld      = 1'b1;
				tag_i.ph       = PH_WIN;
				tag_i.first    = (tap == 4'd0);
				tag_i.last     = (tap == 4'(TAPS - 1));
				tag_i.slot_end = (col == 5'(SUBBANDS - 1));
				coef_i         = win_coef({tap, col});
				vrd_en         = adv;
			end
			default: ;
		endcase
	end

	// control registers and pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			voff_q  <= '{default: '0};
			ch_q    <= 1'b0;
			base_q  <= '0;
			outer_q <= '0;
			inner_q <= '0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s3  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (job_pop) begin
				ch_q            <= job_ch;
				base_q          <= voff_q[job_ch] - 4'd1;
				voff_q[job_ch]  <= voff_q[job_ch] - 4'd1;
				outer_q         <= '0;
				inner_q         <= '0;
			end else if (adv && state_q == BK_MAT) begin
				inner_q <= inner_q + 5'd1;
				if (inner_q == 5'(SUBBANDS - 1))
					outer_q <= outer_q + 6'd1;
			end else if (adv && state_q == BK_WIN) begin
				if (tap == 4'(TAPS - 1)) begin
					inner_q <= '0;
					outer_q <= outer_q + 6'd1;
				end else begin
					inner_q <= inner_q + 5'd1;
				end
			end else if (state_q == BK_DRAIN) begin
				outer_q <= '0;
				inner_q <= '0;
			end
			if (adv) begin
				tag_s1 <= tag_i;
				tag_s2 <= tag_s1;
				tag_s3 <= tag_s2;
			end
		end
	end

	// MAC datapath: operand select, multiply, accumulate
	assign opnd = (tag_s1.ph == PH_MAT) ? V_W'(smp_rdata) : vrd_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s1 <= coef_i;
			prod_s2 <= opnd * coef_s1;
			if (tag_s2.vld)
				acc_s3 <= tag_s2.first ? ACC_W'(prod_s2) : acc_s3 + ACC_W'(prod_s2);
		end
	end

	// round half up, then saturate to V or PCM width
	assign rnd   = (acc_s3 + (ACC_W'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	assign v_ovf = !((&rnd[ACC_W-1:V_W-1]) || !(|rnd[ACC_W-1:V_W-1]));
	assign p_ovf = !((&rnd[ACC_W-1:SMP_W-1]) || !(|rnd[ACC_W-1:SMP_W-1]));
	assign vres  = v_ovf ? (rnd[ACC_W-1] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}})
	                     : rnd[V_W-1:0];
	assign pres  = p_ovf ? (rnd[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}})
	                     : rnd[SMP_W-1:0];

	// V history write: clearing sweep or new matrix output
	assign vwe      = (state_q == BK_CLEAR) || (res_s3 && tag_s3.ph == PH_MAT);
	assign vwr_addr = (state_q == BK_CLEAR) ? clr_q : VAW'({ch_q, base_q, tag_s3.idx});
	assign vwr_data = (state_q == BK_CLEAR) ? '0 : vres;

	always_ff @(posedge clk) begin
		if (vwe)
			vmem[vwr_addr] <= vwr_data;
		if (vrd_en)
			vrd_s1 <= vmem[vrd_addr];
	end

	// PCM output queue
	assign oq_push   = res_s3 && (tag_s3.ph == PH_WIN) && adv;
	assign oq_pop    = out_valid && out_ready;
	assign oq_wr     = oq_pop ? (oq_cnt_q - 2'd1) : oq_cnt_q;
	assign oq_in.ch  = tag_s3.ch;
	assign oq_in.pcm = pres;
	assign oq_in.last = tag_s3.slot_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			oq_cnt_q <= '0;
		else
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(oq_pop);
	end

	// a push into the head slot wins over the shift
	always_ff @(posedge clk) begin
		if (oq_push && !oq_wr[0])
			oq_q[0] <= oq_in;
		else if (oq_pop)
			oq_q[0] <= oq_q[1];
		if (oq_push && oq_wr[0])
			oq_q[1] <= oq_in;
	end

	assign out_valid = (oq_cnt_q != 2'd0);
	assign out_ch    = oq_q[0].ch;
	assign out_pcm   = oq_q[0].pcm;
	assign out_last  = oq_q[0].last;

endmodule

// ===== rtl/polyphase_synthesis_filterbank_core.sv =====
// Top level of the 32-band polyphase synthesis filterbank.
//
// channel  | dir | tdata                  | tuser                          | tlast
// s_axis   | in  | [23:0] subband_sample  | [0] channel, [5:1] subband_idx | -
// m_axis   | out | [23:0] pcm_sample      | [0] pcm_channel                | last_of_slot
//
// A completed slot (subband 31) runs on the one shared MAC as 2048 matrix
// terms, 512 window terms, a pipeline drain and the job pop.
// After reset a clearing pass zeroes all CHANNELS*1024 V history entries
// with s_axis_tready low. A channel's next words wait while its slot is matrixed.
// m_axis stalls hold the MAC once the 2-word output queue is full.
`include "polyphase_synthesis_filterbank_core_assert.svh"

module polyphase_synthesis_filterbank_core
	import psf_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] subband_sample
	input  logic [5:0]  s_axis_tuser,   // [0] channel, [5:1] subband_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [23:0] pcm_sample
	output logic [0:0]  m_axis_tuser,   // [0] pcm_channel
	output logic        m_axis_tlast
);

	back_stat_t              stat;
	smp_rd_t                 smp_rd;
	logic signed [SMP_W-1:0] smp_rdata;
	logic                    job_push;
	logic                    job_ch;
	logic                    job_full;
	logic                    job_valid;
	logic                    job_head;
	logic                    job_pop;
	logic                    out_ch;

	psf_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_ch    (s_axis_tuser[0]),
		.in_sb    (s_axis_tuser[5:1]),
		.in_smp   (s_axis_tdata),
		.stat     (stat),
		.job_push (job_push),
		.job_ch   (job_ch),
		.job_full (job_full),
		.smp_rd   (smp_rd),
		.smp_rdata(smp_rdata)
	);

	psf_job_fifo u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.push_ch(job_ch),
		.full   (job_full),
		.pop    (job_pop),
		.valid  (job_valid),
		.head_ch(job_head)
	);

	psf_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ch   (job_head),
		.job_pop  (job_pop),
		.stat     (stat),
		.smp_rd   (smp_rd),
		.smp_rdata(smp_rdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_ch   (out_ch),
		.out_pcm  (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tuser[0] = out_ch;

	// checks
	`PSF_ASSERT_NOW(a_no_accept_clr, stat.clr_busy, !s_axis_tready, "word taken during V clear")
	`PSF_ASSERT_NOW(a_push_room, job_push, !job_full, "job pushed into a full queue")
	`PSF_ASSERT_NOW(a_rel_push_ch, stat.rel_valid && job_push, stat.rel_ch != job_ch, "job pushed for a channel still matrixing")
	`PSF_ASSERT_NEXT(a_rel_single, stat.rel_valid, !stat.rel_valid, "matrix release repeated")

endmodule

// ===== verif/tb_polyphase_synthesis_filterbank_core.sv =====
// Self-checking testbench for the 32-band polyphase synthesis filterbank core.
module tb_polyphase_synthesis_filterbank_core;
	import psf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 2;

	typedef struct {
		logic              ch;
		logic [4:0]        sb;
		logic [SMP_W-1:0]  smp;
	} subband_word_t;

	typedef struct {
		logic              ch;
		logic [SMP_W-1:0]  pcm;
		logic              last;
	} pcm_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [23:0] subband_sample
	logic [5:0] s_axis_tuser = '0;    // [0] channel, [5:1] subband_index
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;        // [23:0] pcm_sample
	logic [0:0] m_axis_tuser;         // [0] pcm_channel
	logic m_axis_tlast;

	polyphase_synthesis_filterbank_core #(.CHANNELS(NCH)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// filterbank state mirror
	longint cos_lut [0:127];
	longint win_lut [0:WIN_LEN-1];
	logic signed [31:0] v_mem [NCH][HIST_LEN];
	logic [3:0] v_base [NCH];
	logic signed [SMP_W-1:0] slot_mem [NCH][SUBBANDS];

	subband_word_t pending_words[$];
	pcm_word_t expected_pcm[$];
	int errors = 0;
	int pcm_seen = 0;
	bit stim_done = 0;

	function automatic longint rshift_round(longint v);
		return (v + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	// store the sample; on subband 31 rebuild V and emit the 32 PCM words
	task automatic synthesize(input subband_word_t w);
		int b;
		longint acc;
		pcm_word_t p;
		slot_mem[w.ch][w.sb] = w.smp;
		if (w.sb != 5'd31)
			return;
		v_base[w.ch] = v_base[w.ch] - 4'd1;
		b = int'(v_base[w.ch]) * BLOCK;
		for (int i = 0; i < BLOCK; i++) begin
			acc = 0;
			for (int k = 0; k < SUBBANDS; k++)
				acc += cos_lut[((16 + i) * (2 * k + 1)) & 127] * longint'(slot_mem[w.ch][k]);
			v_mem[w.ch][(b + i) & 1023] = 32'(clamp(rshift_round(acc), 32));
		end
		for (int j = 0; j < SUBBANDS; j++) begin
			acc = 0;
			for (int i = 0; i < TAPS; i++)
				acc += longint'(v_mem[w.ch][(b + 128 * (i >> 1) + ((i & 1) ? SECOND_HALF : 0)
					+ j) & 1023]) * win_lut[(32 * i + j) & 511];
			p.ch = w.ch;
			p.pcm = SMP_W'(clamp(rshift_round(acc), SMP_W));
			p.last = (j == 31);
			expected_pcm.push_back(p);
		end
	endtask

	task automatic queue_word(input logic ch, input int sb, input logic [SMP_W-1:0] smp);
		subband_word_t w;
		w.ch = ch;
		w.sb = 5'(sb);
		w.smp = smp;
		pending_words.push_back(w);
	endtask

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return SMP_W'($urandom_range(0, 255)) - 24'd128;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// sender: words change on the falling edge, idles in random bursts
	bit took = 0;
	int send_gap = 0;
	always @(posedge clk) begin
		took <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			subband_word_t w;
			w.ch = s_axis_tuser[0];
			w.sb = s_axis_tuser[5:1];
			w.smp = s_axis_tdata;
			synthesize(w);
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || took)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_words.size() > 0 &&
					(pending_words.size() < 40 || $urandom_range(0, 7) != 0)) begin
				s_axis_tdata <= pending_words[0].smp;
				s_axis_tuser <= {pending_words[0].sb, pending_words[0].ch};
				s_axis_tvalid <= 1'b1;
				void'(pending_words.pop_front());
			end else begin
				if (pending_words.size() > 0)
					send_gap <= $urandom_range(1, 16);
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts, none near the end
	logic rx_ready = 1'b1;
	logic choke = 1'b0;
	int rx_gap = 0;
	assign m_axis_tready = rx_ready && !choke;

	always @(negedge clk) begin
		if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			rx_ready <= 1'b0;
		end else if (pending_words.size() >= 40 && $urandom_range(0, 9) == 0) begin
			rx_gap <= $urandom_range(1, 16);
			rx_ready <= 1'b0;
		end else begin
			rx_ready <= 1'b1;
		end
	end

	// one long hold-off in mid run so the core backs up into its input
	int choke_cnt = 0;
	bit choked_once = 0;
	always @(negedge clk) begin
		if (!choked_once && pcm_seen >= 40) begin
			choked_once <= 1;
			choke_cnt <= 6000;
			choke <= 1'b1;
		end else if (choke_cnt > 1) begin
			choke_cnt <= choke_cnt - 1;
		end else begin
			choke_cnt <= 0;
			choke <= 1'b0;
		end
	end

	// compare each PCM word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pcm_seen <= pcm_seen + 1;
			if (expected_pcm.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected PCM word ch=%0d pcm=%h", m_axis_tuser[0], m_axis_tdata);
			end else begin
				pcm_word_t e;
				e = expected_pcm.pop_front();
				if (e.ch !== m_axis_tuser[0] || e.pcm !== m_axis_tdata ||
						e.last !== m_axis_tlast) begin
					errors++;
					if (errors <= 10)
						$display("PCM mismatch: exp ch=%0d pcm=%h last=%0d, got ch=%0d pcm=%h last=%0d",
							e.ch, e.pcm, e.last, m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int n;
		logic ch;
		// coefficient tables from the packaged quarter wave and window
		for (int m = 0; m < 128; m++) begin
			if (m <= 32) cos_lut[m] = COS_Q[m];
			else if (m <= 64) cos_lut[m] = -COS_Q[64 - m];
			else if (m <= 96) cos_lut[m] = -COS_Q[m - 64];
			else cos_lut[m] = COS_Q[128 - m];
		end
		for (int i = 0; i < WIN_LEN; i++) begin
			win_lut[i] = WIN_BASE[i <= 256 ? i : WIN_LEN - i];
			if ((i >> 6) & 1)
				win_lut[i] = -win_lut[i];
		end
		for (int c = 0; c < NCH; c++) begin
			v_base[c] = '0;
			for (int i = 0; i < HIST_LEN; i++)
				v_mem[c][i] = '0;
		end

		// directed: full-scale slots on both channels, then a slot with skipped subbands
		for (int k = 0; k < 32; k++)
			queue_word(1'b0, k, (k & 1) ? 24'h800000 : 24'h7fffff);
		for (int k = 0; k < 32; k++)
			queue_word(1'b1, k, 24'h7fffff);
		queue_word(1'b1, 0, 24'h800000);
		queue_word(1'b1, 17, 24'h000001);
		queue_word(1'b1, 31, 24'hffffff);

		// random: mostly whole slots, some short runs that break off or skip subbands
		while (pending_words.size() < 215) begin
			ch = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 4) != 0) begin
				for (int k = 0; k < 32; k++)
					queue_word(ch, k, rand_sample());
			end else begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					queue_word(ch, $urandom_range(0, 31), rand_sample());
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		wait (pending_words.size() == 0 && !s_axis_tvalid);
		wait (expected_pcm.size() == 0);
		repeat (3000) @(posedge clk);
		if (errors == 0 && expected_pcm.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psf_pkg.sv
rtl/psf_front.sv
rtl/psf_job_fifo.sv
rtl/psf_back.sv
rtl/polyphase_synthesis_filterbank_core.sv
verif/tb_polyphase_synthesis_filterbank_core.sv
